/* rtl/citq_pkg.sv */
// Shared constants, types and the CORDIC arctangent table for the 2R impedance block.
// No dependencies.
`default_nettype none
package citq_pkg;
    localparam int CORDIC_STEPS = 16;
    localparam int STEPS_EFF = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    localparam int STEP_W = 5;

    localparam logic [33:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic [33:0] Q30_PI      = 34'sd3373259426;
    localparam logic [33:0] Q30_GAIN    = 34'sd652032875;

    localparam logic [2:0] REG_BASE  = 3'd0;
    localparam logic [2:0] REG_L1    = 3'd1;
    localparam logic [2:0] REG_L2    = 3'd2;
    localparam logic [2:0] REG_KSX   = 3'd3;
    localparam logic [2:0] REG_KSY   = 3'd4;
    localparam logic [2:0] REG_KDX   = 3'd5;
    localparam logic [2:0] REG_KDY   = 3'd6;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_SAT     = 2'd2;

    typedef struct packed {
        logic [15:0] base;
        logic [15:0] l1;
        logic [15:0] l2;
        logic [15:0] ksx;
        logic [15:0] ksy;
        logic [15:0] kdx;
        logic [15:0] kdy;
    } cfg_t;

    function automatic logic [33:0] atan_q30(input logic [STEP_W-1:0] i);
        logic [33:0] r;
        unique case (i)
            5'd0:  r = 34'd843314857;
            5'd1:  r = 34'd497837829;
            5'd2:  r = 34'd263043837;
            5'd3:  r = 34'd133525159;
            5'd4:  r = 34'd67021687;
            5'd5:  r = 34'd33543516;
            5'd6:  r = 34'd16775851;
            5'd7:  r = 34'd8388437;
            5'd8:  r = 34'd4194283;
            5'd9:  r = 34'd2097149;
            default: r = 34'd1 << (5'd30 - i);
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

/* rtl/cartesian_impedance_torque_2r_top.sv */
// Top level of the planar 2R Cartesian impedance torque block: sequencer, state
// and output register. Depends on citq_pkg, citq_cordic, citq_mac.
//
//  channel  | ports               | direction
//  s_       | s_valid / s_ready   | in: joint sample and target beat
//  m_       | m_valid / m_ready   | out: status and torque beat
//  cfg      | cfg_we/index/data   | in: register write
//
// A beat with both samples seen goes through the check and the two CORDIC runs,
// then 12 serial products, each with start, 8 digits and hand-off. The result is
// posted from the last product, and s_ready returns once the sequencer is back in
// S_IDLE and the result is taken. The digit-serial multiplier takes most of the time.
// Missing-data beats post their result straight from the check state.
// Reset is synchronous on aresetn; it clears control state and the latched beat and loads configuration defaults.
// One beat is in flight; a held result stalls s_ready until m_ready takes it.
`default_nettype none
module cartesian_impedance_torque_2r_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_joint_valid,
    input  wire logic signed [15:0] s_joint_angle_0,
    input  wire logic signed [15:0] s_joint_angle_1,
    input  wire logic signed [15:0] s_joint_rate_0,
    input  wire logic signed [15:0] s_joint_rate_1,
    input  wire logic        s_target_valid,
    input  wire logic signed [15:0] s_target_x,
    input  wire logic signed [15:0] s_target_y,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic signed [23:0] m_torque_0,
    output logic signed [23:0] m_torque_1
);
    localparam logic [3:0] S_IDLE = 4'd0, S_CS0 = 4'd1, S_CW0 = 4'd2, S_CW1 = 4'd3,
                           S_MUL = 4'd4, S_MW = 4'd5, S_OUT = 4'd6, S_CHK = 4'd7;

    citq_pkg::cfg_t cfg_reg;
    logic [3:0]  state_reg;
    logic [3:0]  op_reg;
    logic signed [15:0] ang_reg [2];
    logic signed [15:0] rate_reg [2];
    logic signed [15:0] tgt_reg [2];
    logic        jseen_reg, tseen_reg;
    logic signed [16:0] c0_reg, s0_reg;
    logic signed [47:0] j00_reg, j01_reg, j10_reg, j11_reg;
    logic signed [47:0] vx_reg, vy_reg, fx_reg, fy_reg, t0_reg, t1_reg;
    logic signed [71:0] acc_reg;
    logic        ov_valid_reg;
    logic [1:0]  ov_status_reg;
    logic signed [23:0] ov_t0_reg, ov_t1_reg;

    logic        cs_start, c_done;
    logic signed [16:0] c_cos, c_sin;
    logic        m_start, m_done;
    logic signed [71:0] m_p;
    logic signed [47:0] ma;
    logic signed [31:0] mb;
    logic signed [71:0] sum, rnd_vel, rnd_f, rnd_t;
    logic        sat0;
    logic signed [23:0] sat_val;

    assign s_ready = (state_reg == S_IDLE) && !ov_valid_reg;
    assign m_valid = ov_valid_reg;
    assign m_status = ov_status_reg;
    assign m_torque_0 = ov_t0_reg;
    assign m_torque_1 = ov_t1_reg;

    citq_cordic u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(cs_start),
        .angle(state_reg == S_CS0 ? ang_reg[0] : ang_reg[1]),
        .done(c_done), .cos_q15(c_cos), .sin_q15(c_sin)
    );

    citq_mac u_mac (
        .aclk(aclk), .aresetn(aresetn), .start(m_start),
        .a(ma), .b(mb), .done(m_done), .p(m_p)
    );

    assign cs_start = (state_reg == S_CS0) || (state_reg == S_CW0 && c_done);
    assign m_start  = (state_reg == S_MUL);

    // Operand select for each product of the sequence
    always_comb begin
        ma = '0;
        mb = '0;
        unique case (op_reg)
            4'd0:  begin ma = j00_reg; mb = 32'(rate_reg[0]); end
            4'd1:  begin ma = j01_reg; mb = 32'(rate_reg[1]); end
            4'd2:  begin ma = j10_reg; mb = 32'(rate_reg[0]); end
            4'd3:  begin ma = j11_reg; mb = 32'(rate_reg[1]); end
            4'd4:  begin ma = (48'(tgt_reg[0]) <<< 17) - (48'({1'b0, cfg_reg.base}) <<< 15)
                               - j10_reg - j11_reg;
                         mb = 32'({1'b0, cfg_reg.ksx}); end
            4'd5:  begin ma = vx_reg; mb = -32'({1'b0, cfg_reg.kdx}); end
            4'd6:  begin ma = (48'(tgt_reg[1]) <<< 17) + j00_reg + j01_reg;
                         mb = 32'({1'b0, cfg_reg.ksy}); end
            4'd7:  begin ma = vy_reg; mb = -32'({1'b0, cfg_reg.kdy}); end
            4'd8:  begin ma = j00_reg; mb = fx_reg[31:0]; end
            4'd9:  begin ma = j10_reg; mb = fy_reg[31:0]; end
            4'd10: begin ma = j01_reg; mb = fx_reg[31:0]; end
            4'd11: begin ma = j11_reg; mb = fy_reg[31:0]; end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    always_comb begin
        sum = acc_reg + m_p;
        rnd_vel = (sum + 72'sd1024) >>> 11;
        rnd_f = (sum + 72'sd4194304) >>> 23;
        rnd_t = (sum + 72'sd1073741824) >>> 31;
        sat0 = 1'b0;
        if (rnd_t > 72'sd8388607) begin
            sat_val = 24'sh7FFFFF; sat0 = 1'b1;
        end else if (rnd_t < -72'sd8388608) begin
            sat_val = 24'sh800000; sat0 = 1'b1;
        end else begin
            sat_val = rnd_t[23:0];
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{16'd8323, 16'd13107, 16'd13107, 16'd3968, 16'd3584,
                         16'd230, 16'd205};
        end else if (cfg_we) begin
            unique case (cfg_index)
                citq_pkg::REG_BASE: cfg_reg.base <= cfg_data;
                citq_pkg::REG_L1:   cfg_reg.l1   <= cfg_data;
                citq_pkg::REG_L2:   cfg_reg.l2   <= cfg_data;
                citq_pkg::REG_KSX:  cfg_reg.ksx  <= cfg_data;
                citq_pkg::REG_KSY:  cfg_reg.ksy  <= cfg_data;
                citq_pkg::REG_KDX:  cfg_reg.kdx  <= cfg_data;
                citq_pkg::REG_KDY:  cfg_reg.kdy  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer: latch beat, check for missing data, two CORDIC runs, twelve serial products
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            op_reg       <= '0;
            jseen_reg    <= 1'b0;
            tseen_reg    <= 1'b0;
            ov_valid_reg <= 1'b0;
            ang_reg[0] <= '0; ang_reg[1] <= '0;
            rate_reg[0] <= '0; rate_reg[1] <= '0;
            tgt_reg[0] <= '0; tgt_reg[1] <= '0;
        end else begin
            if (ov_valid_reg && m_ready) ov_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        if (s_joint_valid) begin
                            ang_reg[0] <= s_joint_angle_0; ang_reg[1] <= s_joint_angle_1;
                            rate_reg[0] <= s_joint_rate_0; rate_reg[1] <= s_joint_rate_1;
                            jseen_reg <= 1'b1;
                        end
                        if (s_target_valid) begin
                            tgt_reg[0] <= s_target_x; tgt_reg[1] <= s_target_y;
                            tseen_reg <= 1'b1;
                        end
                        state_reg <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (!jseen_reg || !tseen_reg) begin
                        ov_status_reg <= citq_pkg::ST_MISSING;
                        ov_t0_reg <= '0; ov_t1_reg <= '0;
                        ov_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end else begin
                        state_reg <= S_CS0;
                    end
                end
                S_CS0: state_reg <= S_CW0;
                S_CW0: begin
                    if (c_done) begin
                        c0_reg <= c_cos; s0_reg <= c_sin;
                        state_reg <= S_CW1;
                    end
                end
                S_CW1: begin
                    // Jacobian entries: 17x17-bit products, two per link
                    if (c_done) begin
                        j00_reg <= -(48'({1'b0, cfg_reg.l1}) * 48'(s0_reg));
                        j10_reg <= 48'({1'b0, cfg_reg.l1}) * 48'(c0_reg);
                        j01_reg <= -(48'({1'b0, cfg_reg.l2}) * 48'(c_sin));
                        j11_reg <= 48'({1'b0, cfg_reg.l2}) * 48'(c_cos);
                        op_reg <= '0;
                        acc_reg <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: state_reg <= S_MW;
                S_MW: begin
                    if (m_done) begin
                        state_reg <= (op_reg == 4'd11) ? S_OUT : S_MUL;
                        op_reg <= op_reg + 1'b1;
                        if (!op_reg[0]) begin
                            acc_reg <= sum;
                        end else begin
                            acc_reg <= '0;
                            unique case (op_reg)
                                4'd1: vx_reg <= rnd_vel[47:0];
                                4'd3: vy_reg <= rnd_vel[47:0];
                                4'd5: fx_reg <= rnd_f[47:0];
                                4'd7: fy_reg <= rnd_f[47:0];
                                4'd9: begin
                                    t0_reg <= 48'(sat_val);
                                    t1_reg <= {47'd0, sat0};
                                end
                                default: begin
                                    ov_t0_reg <= t0_reg[23:0];
                                    ov_t1_reg <= sat_val;
                                    ov_status_reg <= (sat0 || t1_reg[0]) ?
                                        citq_pkg::ST_SAT : citq_pkg::ST_OK;
                                    ov_valid_reg <= 1'b1;
                                end
                            endcase
                        end
                    end
                end
                S_OUT: state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* rtl/citq_cordic.sv */
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, Q2.30.
// Depends on citq_pkg.
`default_nettype none
module citq_cordic (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [15:0] angle,
    output logic                    done,
    output logic signed [16:0]      cos_q15,
    output logic signed [16:0]      sin_q15
);
    logic signed [35:0] x_reg, y_reg, z_reg;
    logic               neg_reg, busy_reg, done_reg;
    logic [citq_pkg::STEP_W-1:0] i_reg;

    logic signed [35:0] z0, xs, ys, at, xf, yf;
    logic signed [35:0] cr, sr;
    logic signed [35:0] half_pi;

    always_comb begin
        z0 = 36'(angle) <<< 17;
        half_pi = $signed(36'(citq_pkg::Q30_HALF_PI));
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        at = 36'(citq_pkg::atan_q30(i_reg));
        xf = neg_reg ? -x_reg : x_reg;
        yf = neg_reg ? -y_reg : y_reg;
        cr = (xf + 36'sd16384) >>> 15;
        sr = (yf + 36'sd16384) >>> 15;
    end

    assign done = done_reg;
    assign cos_q15 = cr[16:0];
    assign sin_q15 = sr[16:0];

    // Load, then rotate one step per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                x_reg   <= 36'(citq_pkg::Q30_GAIN);
                y_reg   <= '0;
                i_reg   <= '0;
                busy_reg <= 1'b1;
                if (z0 > half_pi) begin
                    z_reg <= z0 - 36'(citq_pkg::Q30_PI); neg_reg <= 1'b1;
                end else if (z0 < -half_pi) begin
                    z_reg <= z0 + 36'(citq_pkg::Q30_PI); neg_reg <= 1'b1;
                end else begin
                    z_reg <= z0; neg_reg <= 1'b0;
                end
            end else if (busy_reg) begin
                if (z_reg >= 0) begin
                    x_reg <= x_reg - ys; y_reg <= y_reg + xs; z_reg <= z_reg - at;
                end else begin
                    x_reg <= x_reg + ys; y_reg <= y_reg - xs; z_reg <= z_reg + at;
                end
                i_reg <= i_reg + 1'b1;
                if (i_reg == citq_pkg::STEP_W'(citq_pkg::STEPS_EFF - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/citq_mac.sv */
// Serial-parallel multiplier: a 48-bit signed multiplicand times a 32-bit signed
// multiplier, one multiplier digit of 4 bits a cycle, eight digits in all. No package use.
`default_nettype none
module citq_mac (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [47:0] a,
    input  wire logic signed [31:0] b,
    output logic                    done,
    output logic signed [71:0]      p
);
    logic signed [71:0] acc_reg;
    logic signed [71:0] a_reg;
    logic [31:0]        b_reg;
    logic [2:0]         cnt_reg;
    logic               busy_reg, done_reg;
    logic signed [71:0] part;

    // Top digit carries the sign weight
    always_comb begin
        if (cnt_reg == 3'd7)
            part = a_reg * 72'(signed'({1'b0, b_reg[3:0]} - (b_reg[3] ? 5'sd16 : 5'sd0)));
        else
            part = a_reg * 72'(signed'({1'b0, b_reg[3:0]}));
    end

    assign done = done_reg;
    assign p = acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                acc_reg  <= '0;
                a_reg    <= 72'(a);
                b_reg    <= b;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                acc_reg <= acc_reg + part;
                a_reg   <= a_reg <<< 4;
                b_reg   <= b_reg >> 4;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 3'd7) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/citq_checker.sv */
// Port-level checks for the impedance torque top level, attached by bind.
// Depends on cartesian_impedance_torque_2r_top ports only.
`default_nettype none
module citq_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_status,
    input wire logic [23:0] m_torque_0,
    input wire logic [23:0] m_torque_1
);
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status != 2'd3) else $error("bad status code");
    a_missing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == 2'd1) |-> (m_torque_0 == 24'd0 && m_torque_1 == 24'd0))
        else $error("missing data with nonzero torque");
    a_no_accept_while_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready) else $error("accept while result held");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_torque_0) && $stable(m_torque_1)
                                   && $stable(m_status)))
        else $error("result dropped");
endmodule

bind cartesian_impedance_torque_2r_top citq_checker u_citq_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
    .m_torque_0(m_torque_0), .m_torque_1(m_torque_1)
);
`default_nettype wire
